### src/stkt_pkg.sv
package stkt_pkg;

   // Table geometry.
   localparam int DEPTH      = 10;
   localparam int NAME_BYTES = 8;
   localparam int IDX_W      = $clog2(DEPTH);

   // Fixed field widths of the request and response transactions.
   localparam int NAME_W     = 64;
   localparam int NAME_LANES = NAME_W / 8;
   localparam int SCORE_W    = 32;
   localparam int SLOT_W     = 6;
   localparam int POS_W      = 5;

   typedef logic [NAME_W-1:0]         name_type;
   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic [SLOT_W-1:0]         slot_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [IDX_W-1:0]          idx_type;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_READ   = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_FIND   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_REJECT   = 2'd1,
      ST_RANGE    = 2'd2,
      ST_NO_MATCH = 2'd3
   } status_type;

   localparam idx_type  IDX_LAST   = idx_type'(DEPTH - 1);
   localparam idx_type  IDX_PRE    = idx_type'(DEPTH - 2);
   localparam slot_type DEPTH_SLOT = slot_type'(DEPTH);

   // Keep the low NAME_BYTES bytes and clear everything after the first zero byte,
   // so that two names compare equal exactly when the strings do.
   function automatic name_type norm_name(input name_type raw);
      name_type res;
      logic     live;
      res  = '0;
      live = 1'b1;
      for (int i = 0; i < NAME_LANES; i++) begin
         if (i >= NAME_BYTES || raw[8*i +: 8] == 8'h00) begin
            live = 1'b0;
         end
         if (live) begin
            res[8*i +: 8] = raw[8*i +: 8];
         end
      end
      return res;
   endfunction

   // The string "(Empty)" with its first character in the low byte.
   localparam name_type EMPTY_NAME_RAW = 64'h0029_7974_706D_4528;
   localparam name_type EMPTY_NAME     = norm_name(EMPTY_NAME_RAW);

endpackage

### src/sorted_top_k_table_top.sv
// Sorted top-k table: DEPTH entries of a name and a signed score, kept in descending score
// order in a dual-port synchronous memory (one read and one write per cycle, read data
// registered). One request transaction is worked at a time; the request side is stalled
// until its last response is loaded into the output register, which then waits on its own.
// Every step that touches the table moves one entry per cycle through that memory, unless a
// stalled output holds a find, so the cost of a request follows the entries it visits: read
// fetches its entry, remove walks from the index to the bottom, insert checks the bottom and
// top and walks up from the bottom to its place, find counts matches over the whole table and
// walks down to the last match; rejects and out-of-range requests skip the walk, and response
// stalls add to any request. After reset the table reads as all "(Empty)" with score 0 at once;
// per-entry valid flags stand in for the reset contents, so no clearing pass is needed.
module sorted_top_k_table_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  stkt_pkg::req_kind_type   req_type,
   input  stkt_pkg::name_type       req_key_name,
   input  stkt_pkg::score_type      req_new_score,
   input  stkt_pkg::slot_type       req_slot_index,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output stkt_pkg::status_type     rsp_status,
   output stkt_pkg::pos_type        rsp_entry_position,
   output stkt_pkg::name_type       rsp_entry_name,
   output stkt_pkg::score_type      rsp_entry_score,
   output logic                     rsp_last_of_run
);
   import stkt_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_INS_BOT  = 10'b00_0000_0010,
      S_INS_TOP  = 10'b00_0000_0100,
      S_INS_SCAN = 10'b00_0000_1000,
      S_INS_PUT  = 10'b00_0001_0000,
      S_RD_WAIT  = 10'b00_0010_0000,
      S_REM_SCAN = 10'b00_0100_0000,
      S_F_CNT    = 10'b00_1000_0000,
      S_F_EMIT   = 10'b01_0000_0000,
      S_OUT      = 10'b10_0000_0000
   } state_type;

   // Control state.
   state_type        state_ff, state_in;
   logic [DEPTH-1:0] ent_valid_ff, ent_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers of the current transaction.
   idx_type      cur_ff, cur_in;
   idx_type      pos_ff, pos_in;
   idx_type      idx_ff, idx_in;
   idx_type      last_ff, last_in;
   logic         top_ff, top_in;
   logic         hit_ff, hit_in;
   req_kind_type kind_ff, kind_in;
   name_type     key_ff, key_in;
   score_type    score_ff, score_in;

   // Pending single response, sent from S_OUT.
   status_type res_status_ff, res_status_in;
   pos_type    res_pos_ff, res_pos_in;
   name_type   res_name_ff, res_name_in;
   score_type  res_score_ff, res_score_in;

   // Output register.
   status_type rsp_status_ff, rsp_status_in;
   pos_type    rsp_pos_ff, rsp_pos_in;
   name_type   rsp_name_ff, rsp_name_in;
   score_type  rsp_score_ff, rsp_score_in;
   logic       rsp_last_ff, rsp_last_in;

   // Table memory and its port.
   name_type  tbl_name_mem [DEPTH];
   score_type tbl_score_mem [DEPTH];
   name_type  rd_name_ff;
   score_type rd_score_ff;
   logic      rd_val_ff;
   idx_type   rd_addr;
   logic      wr_en;
   idx_type   wr_addr;
   name_type  wr_name;
   score_type wr_score;
   logic      clr_last;

   // Helpers.
   name_type  ent_name;
   score_type ent_score;
   logic      out_free;
   logic      out_load;
   logic      ent_match;
   logic      shift_down;
   idx_type   cur_inc;
   idx_type   cur_dec;

   // An entry never written since reset, or cleared by a remove, reads as the empty entry.
   assign ent_name  = rd_val_ff ? rd_name_ff : EMPTY_NAME;
   assign ent_score = rd_val_ff ? rd_score_ff : '0;
   assign ent_match = (ent_name == key_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_inc   = cur_ff + idx_type'(1);
   assign cur_dec   = cur_ff - idx_type'(1);
   assign shift_down = top_ff || (cur_ff != '0 && score_ff >= ent_score);

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_entry_name     = rsp_name_ff;
   assign rsp_entry_score    = rsp_score_ff;
   assign rsp_last_of_run    = rsp_last_ff;

   // Sequencer: issues one table read per cycle and acts on the data of the previous one.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      top_in        = top_ff;
      hit_in        = hit_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      score_in      = score_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_name_in   = res_name_ff;
      res_score_in  = res_score_ff;
      rd_addr       = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_name       = ent_name;
      wr_score      = ent_score;
      clr_last      = 1'b0;
      out_load      = 1'b0;
      rsp_status_in = res_status_ff;
      rsp_pos_in    = res_pos_ff;
      rsp_name_in   = res_name_ff;
      rsp_score_in  = res_score_ff;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_type;
               key_in   = norm_name(req_key_name);
               score_in = req_new_score;
               idx_in   = req_slot_index[IDX_W-1:0];
               unique case (req_type)
                  REQ_INSERT: begin
                     rd_addr  = IDX_LAST;
                     state_in = S_INS_BOT;
                  end
                  REQ_READ, REQ_REMOVE: begin
                     if (req_slot_index < DEPTH_SLOT) begin
                        rd_addr  = req_slot_index[IDX_W-1:0];
                        state_in = S_RD_WAIT;
                     end else begin
                        res_status_in = ST_RANGE;
                        res_pos_in    = '0;
                        res_name_in   = '0;
                        res_score_in  = '0;
                        state_in      = S_OUT;
                     end
                  end
                  REQ_FIND: begin
                     rd_addr  = '0;
                     cur_in   = '0;
                     hit_in   = 1'b0;
                     state_in = S_F_CNT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Reject when the new score is below the bottom entry.
         S_INS_BOT: begin
            if (score_ff < ent_score) begin
               res_status_in = ST_REJECT;
               res_pos_in    = '0;
               res_name_in   = '0;
               res_score_in  = '0;
               state_in      = S_OUT;
            end else begin
               rd_addr  = '0;
               state_in = S_INS_TOP;
            end
         end

         // A score at or above the top entry goes to the top and moves everything down.
         S_INS_TOP: begin
            top_in   = (score_ff >= ent_score);
            cur_in   = IDX_PRE;
            rd_addr  = IDX_PRE;
            state_in = S_INS_SCAN;
         end

         // Walk up from the bottom, moving each passed entry one place down.
         S_INS_SCAN: begin
            if (shift_down) begin
               wr_en   = 1'b1;
               wr_addr = cur_inc;
               if (cur_ff == '0) begin
                  pos_in   = '0;
                  state_in = S_INS_PUT;
               end else begin
                  cur_in  = cur_dec;
                  rd_addr = cur_dec;
               end
            end else begin
               pos_in   = cur_inc;
               state_in = S_INS_PUT;
            end
         end

         S_INS_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff;
            wr_name       = key_ff;
            wr_score      = score_ff;
            res_status_in = ST_OK;
            res_pos_in    = pos_type'(pos_ff);
            res_name_in   = key_ff;
            res_score_in  = score_ff;
            state_in      = S_OUT;
         end

         // Report the addressed entry; a remove then closes the gap.
         S_RD_WAIT: begin
            res_status_in = ST_OK;
            res_pos_in    = pos_type'(idx_ff);
            res_name_in   = ent_name;
            res_score_in  = ent_score;
            if (kind_ff == REQ_REMOVE) begin
               if (idx_ff == IDX_LAST) begin
                  clr_last = 1'b1;
                  state_in = S_OUT;
               end else begin
                  cur_in   = idx_ff;
                  rd_addr  = idx_ff + idx_type'(1);
                  state_in = S_REM_SCAN;
               end
            end else begin
               state_in = S_OUT;
            end
         end

         // Data here is the entry below cur; it moves up into cur.
         S_REM_SCAN: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            if (cur_inc == IDX_LAST) begin
               clr_last = 1'b1;
               state_in = S_OUT;
            end else begin
               cur_in  = cur_inc;
               rd_addr = cur_inc + idx_type'(1);
            end
         end

         // First pass of a find: note whether anything matches and where the last match is.
         S_F_CNT: begin
            if (ent_match) begin
               hit_in  = 1'b1;
               last_in = cur_ff;
            end
            if (cur_ff == IDX_LAST) begin
               if (hit_ff || ent_match) begin
                  cur_in   = '0;
                  rd_addr  = '0;
                  state_in = S_F_EMIT;
               end else begin
                  res_status_in = ST_NO_MATCH;
                  res_pos_in    = '0;
                  res_name_in   = '0;
                  res_score_in  = '0;
                  state_in      = S_OUT;
               end
            end else begin
               cur_in  = cur_inc;
               rd_addr = cur_inc;
            end
         end

         // Second pass: send each match; the read address holds while the output is busy.
         S_F_EMIT: begin
            if (ent_match) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_pos_in    = pos_type'(cur_ff);
                  rsp_name_in   = ent_name;
                  rsp_score_in  = ent_score;
                  rsp_last_in   = (cur_ff == last_ff);
                  if (cur_ff == last_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     cur_in  = cur_inc;
                     rd_addr = cur_inc;
                  end
               end
            end else begin
               cur_in  = cur_inc;
               rd_addr = cur_inc;
            end
         end

         S_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry valid flags: set by any write, cleared at the bottom when a remove empties it.
   always_comb begin
      ent_valid_in = ent_valid_ff;
      if (wr_en) begin
         ent_valid_in[wr_addr] = 1'b1;
      end
      if (clr_last) begin
         ent_valid_in[IDX_LAST] = 1'b0;
      end
   end

   // Output register holds a response transaction until the receiver takes it.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ent_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ent_valid_ff <= ent_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      top_ff        <= top_in;
      hit_ff        <= hit_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      score_ff      <= score_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_name_ff   <= res_name_in;
      res_score_ff  <= res_score_in;
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_name_ff   <= rsp_name_in;
         rsp_score_ff  <= rsp_score_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Table memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_name_mem[wr_addr]  <= wr_name;
         tbl_score_mem[wr_addr] <= wr_score;
      end
      rd_name_ff  <= tbl_name_mem[rd_addr];
      rd_score_ff <= tbl_score_mem[rd_addr];
      rd_val_ff   <= ent_valid_ff[rd_addr];
   end

   // A find response always carries the name that was searched for.
   a_find_name: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_F_EMIT && out_load) |=> (rsp_name_ff == $past(key_ff)))
      else $error("find response name differs from the search key");

   // The emit pass only runs after the count pass saw a match, and never passes the last one.
   a_find_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_F_EMIT) |-> (hit_ff && cur_ff <= last_ff))
      else $error("find emit pass outside the matched range");

   // The remove walk stays above the bottom entry, which is emptied separately.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM_SCAN) |-> (cur_ff < IDX_LAST))
      else $error("remove walk ran past the table");

   // The insert position always lies inside the table.
   a_ins_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_PUT) |-> (pos_ff <= IDX_LAST))
      else $error("insert position outside the table");

endmodule

### verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import stkt_pkg::*;

   // One request transaction as queued for the driver.
   typedef struct {
      req_kind_type kind;
      name_type     key;
      score_type    score;
      slot_type     slot;
      bit           drain_first;
   } table_request_type;

   // One response transaction as the block should produce it.
   typedef struct packed {
      status_type st;
      pos_type    pos;
      name_type   nm;
      score_type  sc;
      logic       last;
   } table_reply_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_kind_type req_type = REQ_READ;
   name_type     req_key_name = '0;
   score_type    req_new_score = '0;
   slot_type     req_slot_index = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   status_type   rsp_status;
   pos_type      rsp_entry_position;
   name_type     rsp_entry_name;
   score_type    rsp_entry_score;
   logic         rsp_last_of_run;

   // Shadow copy of the table, kept in step with accepted requests.
   name_type     board_name [DEPTH];
   score_type    board_score[DEPTH];

   table_request_type pending_requests[$];
   table_reply_type   expected_replies[$];
   table_request_type in_flight;

   int unsigned  request_total = 0;
   int unsigned  requests_taken = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  send_hold = 0;
   int unsigned  sink_hold = 0;
   bit           send_noisy = 1'b1;
   bit           sink_noisy = 1'b1;

   sorted_top_k_table_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_key_name       (req_key_name),
      .req_new_score      (req_new_score),
      .req_slot_index     (req_slot_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_entry_position (rsp_entry_position),
      .rsp_entry_name     (rsp_entry_name),
      .rsp_entry_score    (rsp_entry_score),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Names compare as C strings: keep bytes up to the first zero byte only.
   function automatic name_type clean_name(input name_type raw);
      name_type kept;
      kept = '0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (raw[8*b +: 8] == 8'h00) break;
         kept[8*b +: 8] = raw[8*b +: 8];
      end
      return kept;
   endfunction

   function automatic void clear_board();
      for (int i = 0; i < DEPTH; i++) begin
         board_name[i]  = clean_name(EMPTY_NAME_RAW);
         board_score[i] = '0;
      end
   endfunction

   function automatic void expect_reply(input status_type st, input int at, input name_type nm,
                                        input score_type sc, input logic last);
      table_reply_type r;
      r.st   = st;
      r.pos  = pos_type'(at);
      r.nm   = nm;
      r.sc   = sc;
      r.last = last;
      expected_replies.push_back(r);
   endfunction

   // Apply one accepted request to the shadow table and queue its responses.
   function automatic void update_score_table(input table_request_type rq);
      name_type key;
      int       at;
      int       hits;
      key = clean_name(rq.key);
      case (rq.kind)
         REQ_INSERT: begin
            if (rq.score < board_score[DEPTH-1]) begin
               expect_reply(ST_REJECT, 0, '0, '0, 1'b1);
            end else begin
               // Equal scores stay below the new entry; the scan stops at position 1.
               if (rq.score >= board_score[0]) begin
                  at = 0;
               end else begin
                  at = DEPTH - 1;
                  while (at > 1 && rq.score >= board_score[at-1]) at--;
               end
               for (int i = DEPTH - 1; i > at; i--) begin
                  board_name[i]  = board_name[i-1];
                  board_score[i] = board_score[i-1];
               end
               board_name[at]  = key;
               board_score[at] = rq.score;
               expect_reply(ST_OK, at, key, rq.score, 1'b1);
            end
         end
         REQ_READ, REQ_REMOVE: begin
            if (rq.slot >= DEPTH) begin
               expect_reply(ST_RANGE, 0, '0, '0, 1'b1);
            end else begin
               at = rq.slot;
               expect_reply(ST_OK, at, board_name[at], board_score[at], 1'b1);
               if (rq.kind == REQ_REMOVE) begin
                  for (int i = at; i < DEPTH - 1; i++) begin
                     board_name[i]  = board_name[i+1];
                     board_score[i] = board_score[i+1];
                  end
                  board_name[DEPTH-1]  = clean_name(EMPTY_NAME_RAW);
                  board_score[DEPTH-1] = '0;
               end
            end
         end
         default: begin
            // Find: every matching entry from the top down, last one marked.
            hits = 0;
            for (int i = 0; i < DEPTH; i++) begin
               if (board_name[i] == key) begin
                  expect_reply(ST_OK, i, board_name[i], board_score[i], 1'b0);
                  hits++;
               end
            end
            if (hits == 0) begin
               expect_reply(ST_NO_MATCH, 0, '0, '0, 1'b1);
            end else begin
               expected_replies[expected_replies.size()-1].last = 1'b1;
            end
         end
      endcase
   endfunction

   function automatic void add_request(input req_kind_type kind, input name_type key,
                                       input score_type score, input int slot,
                                       input bit drain_first);
      table_request_type rq;
      rq.kind        = kind;
      rq.key         = key;
      rq.score       = score;
      rq.slot        = slot_type'(slot);
      rq.drain_first = drain_first;
      pending_requests.push_back(rq);
      request_total++;
   endfunction

   // Mostly short names from a small pool so that finds hit, plus raw noise.
   function automatic name_type pick_name();
      name_type pool[5];
      name_type base;
      pool[0] = 64'h41;
      pool[1] = 64'h6F42;
      pool[2] = 64'h74_6143;
      pool[3] = 64'h6576_6F44;
      pool[4] = 64'h65_6C67_6145;
      base = pool[$urandom_range(0, 4)];
      case ($urandom_range(0, 9))
         6:       return EMPTY_NAME_RAW;
         7:       return {$urandom, $urandom};
         8:       return base | (name_type'($urandom_range(1, 255)) << 56);
         9:       return '0;
         default: return base;
      endcase
   endfunction

   function automatic score_type pick_score();
      case ($urandom_range(0, 9))
         7:       return score_type'($urandom);
         8:       return score_type'(32'h7FFF_FFFF);
         9:       return score_type'(32'h8000_0000);
         default: return score_type'($urandom_range(0, 40));
      endcase
   endfunction

   // Request driver: presents queued transactions with random gaps between them.
   always @(posedge clock) begin : request_driver
      table_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_hold = 0;
         clear_board();
      end else begin
         if (req_valid && !req_stall) begin
            update_score_table(in_flight);
            requests_taken++;
            if ($urandom_range(0, 15) == 0) send_noisy = !send_noisy;
            send_hold = send_noisy ? $urandom_range(0, 14) : 0;
         end
         if (req_valid && req_stall) begin
            // Stalled: the payload stays as it is.
         end else if (send_hold > 0) begin
            send_hold--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain_first && expected_replies.size() != 0)) begin
            nxt = pending_requests.pop_front();
            in_flight = nxt;
            req_valid      <= 1'b1;
            req_type       <= nxt.kind;
            req_key_name   <= nxt.key;
            req_new_score  <= nxt.score;
            req_slot_index <= nxt.slot;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response sink: stalls for a random number of cycles after each transaction.
   always @(posedge clock) begin : response_sink
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if ($urandom_range(0, 15) == 0) sink_noisy = !sink_noisy;
            sink_hold = sink_noisy ? $urandom_range(0, 14) : 0;
         end else if (sink_hold > 0) begin
            sink_hold--;
         end
         rsp_stall <= (sink_hold > 0);
      end
   end

   // Response checker: compares each accepted transaction with the oldest expectation.
   always @(posedge clock) begin : response_checker
      table_reply_type seen;
      table_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = '{rsp_status, rsp_entry_position, rsp_entry_name, rsp_entry_score,
                  rsp_last_of_run};
         if (expected_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected response st=%0d pos=%0d name=%h score=%0d last=%0b",
                        $time, seen.st, seen.pos, seen.nm, seen.sc, seen.last);
         end else begin
            want = expected_replies.pop_front();
            if (seen.st !== want.st || seen.pos !== want.pos || seen.nm !== want.nm ||
                seen.sc !== want.sc || seen.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: mismatch expected st=%0d pos=%0d name=%h score=%0d last=%0b",
                           $time, want.st, want.pos, want.nm, want.sc, want.last);
                  $display("%0t:          actual   st=%0d pos=%0d name=%h score=%0d last=%0b",
                           $time, seen.st, seen.pos, seen.nm, seen.sc, seen.last);
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      int           pick;
      req_kind_type kind;
      int           slot;

      // Directed part: empty table, name forms, score extremes, index bounds.
      add_request(REQ_READ,   '0, '0, 0, 1'b0);
      add_request(REQ_FIND,   EMPTY_NAME_RAW, '0, 0, 1'b0);
      add_request(REQ_FIND,   '0, '0, 0, 1'b0);
      add_request(REQ_INSERT, 64'h5A5A_0000_0000_0041, '0, 0, 1'b0);
      add_request(REQ_INSERT, '0, '0, 0, 1'b0);
      add_request(REQ_FIND,   '0, '0, 0, 1'b0);
      add_request(REQ_INSERT, 64'h45, score_type'(-1), 0, 1'b0);
      add_request(REQ_INSERT, 64'h46, score_type'(32'h8000_0000), 0, 1'b0);
      add_request(REQ_INSERT, '1, score_type'(32'h7FFF_FFFF), 63, 1'b0);
      add_request(REQ_INSERT, 64'h42, score_type'(5), 0, 1'b0);
      add_request(REQ_INSERT, 64'h43, score_type'(5), 0, 1'b0);
      add_request(REQ_INSERT, 64'h44, '0, 0, 1'b0);
      add_request(REQ_FIND,   64'h41, '0, 0, 1'b0);
      add_request(REQ_READ,   '0, '0, DEPTH - 1, 1'b0);
      add_request(REQ_READ,   '0, '0, DEPTH, 1'b0);
      add_request(REQ_READ,   '0, '0, 63, 1'b0);
      add_request(REQ_REMOVE, '0, '0, DEPTH, 1'b1);
      add_request(REQ_REMOVE, '0, '0, 63, 1'b0);
      add_request(REQ_REMOVE, '0, '0, 0, 1'b0);
      add_request(REQ_REMOVE, '0, '0, DEPTH - 1, 1'b0);
      add_request(REQ_FIND,   EMPTY_NAME_RAW, '0, 0, 1'b0);

      // Random part, with an occasional full drain before a request.
      for (int n = 0; n < 200; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)      kind = REQ_INSERT;
         else if (pick < 55) kind = REQ_READ;
         else if (pick < 70) kind = REQ_REMOVE;
         else                kind = REQ_FIND;
         slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, DEPTH - 1);
         add_request(kind, pick_name(), pick_score(), slot, (n % 60) == 30);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken != request_total || expected_replies.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (expected_replies.size() != 0)
         $display("%0d expected responses never arrived", expected_replies.size());
      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("** sorted_top_k_table_top: PASSED **");
      end else begin
         $display("** sorted_top_k_table_top: FAILED **");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #2_000_000;
      $display("timeout with %0d responses outstanding", expected_replies.size());
      $display("** sorted_top_k_table_top: FAILED **");
      $finish;
   end

endmodule
